### hdl/uitf_pkg.sv
`timescale 1ns / 1ps
// Package for the UART receive idle-timeout framer.
// Types, codes and defaults shared by the interfaces, controller and datapath. No dependencies.
package uitf_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 64;
  localparam int unsigned OP_W             = 2;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned LEN_W            = 7;
  localparam int unsigned CFG_W            = 8;

  localparam logic [CFG_W-1:0] TICK_PERIOD_RST = 8'd1;
  localparam logic [CFG_W-1:0] IDLE_LIMIT_RST  = 8'd30;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2
  } uitf_op_e;

  typedef enum logic {
    CFG_TICK_PERIOD = 1'b0,
    CFG_IDLE_LIMIT  = 1'b1
  } uitf_cfg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } uitf_state_e;

  // controller -> datapath
  typedef struct packed {
    logic wr_byte;      // store a received byte
    logic tick;         // run the idle timer
    logic rd_clear;     // latch read length, clear count/flag, fetch first byte
    logic push_status;  // emit one status result
    logic push_data;    // emit the fetched byte, fetch the next one
  } uitf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic space;        // output buffer can take a result
    logic rd_none;      // a read now would return nothing
    logic rd_last;      // byte held for output is the final one of the read
  } uitf_sts_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              last;
    logic              frame_ready;
    logic [LEN_W-1:0]  returned_length;
  } uitf_res_t;

endpackage

### hdl/uitf_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the framer: command input and result output.
// Depends on uitf_pkg for field widths.
interface uitf_in_if;
  import uitf_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] read_length;

  modport source (output valid, output opcode, output rx_byte, output read_length,
                  input ready);
  modport sink   (input valid, input opcode, input rx_byte, input read_length,
                  output ready);
endinterface

interface uitf_out_if;
  import uitf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              data_valid;
  logic              last;
  logic              frame_ready;
  logic [LEN_W-1:0]  returned_length;

  modport source (output valid, output data_byte, output data_valid, output last,
                  output frame_ready, output returned_length, input ready);
  modport sink   (input valid, input data_byte, input data_valid, input last,
                  input frame_ready, input returned_length, output ready);
endinterface

### hdl/uitf_ctrl.sv
`timescale 1ns / 1ps
// Controller of the framer: decodes accepted transactions and sequences reads.
// Depends on uitf_pkg.
module uitf_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [uitf_pkg::OP_W-1:0] in_opcode_i,
  output logic                    in_ready_o,
  input  uitf_pkg::uitf_sts_t     sts_i,
  output uitf_pkg::uitf_cmd_t     cmd_o
);
  import uitf_pkg::*;

  uitf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.space;
        if (in_valid_i && sts_i.space) begin
          case (uitf_op_e'(in_opcode_i))
            OP_BYTE: begin
              cmd_o.wr_byte     = 1'b1;
              cmd_o.push_status = 1'b1;
            end
            OP_TICK: begin
              cmd_o.tick        = 1'b1;
              cmd_o.push_status = 1'b1;
            end
            OP_READ: begin
              cmd_o.rd_clear = 1'b1;
              if (sts_i.rd_none) begin
                cmd_o.push_status = 1'b1;
              end else begin
                state_d = ST_READ;
              end
            end
            default: begin
              cmd_o.push_status = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (sts_i.space) begin
          cmd_o.push_data = 1'b1;
          if (sts_i.rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/uitf_dp.sv
`timescale 1ns / 1ps
// Datapath of the framer: byte store, counters, idle timer, config and output buffer.
// Depends on uitf_pkg; driven by uitf_ctrl commands.
module uitf_dp #(
  parameter int unsigned BUFFER_DEPTH = uitf_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [uitf_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic [uitf_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic [uitf_pkg::BYTE_W-1:0]   read_length_i,
  input  uitf_pkg::uitf_cmd_t           cmd_i,
  output uitf_pkg::uitf_sts_t           sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output uitf_pkg::uitf_res_t           out_res_o
);
  import uitf_pkg::*;

  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  // config
  logic [CFG_W-1:0] tick_period_q, idle_limit_q;

  // frame state
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  seen_q, seen_d;
  logic [BYTE_W-1:0] timer_q, timer_d;
  logic              flag_q, flag_d;

  // read walk
  logic [CNT_W-1:0]  rd_n_q, rd_n_d, rd_n_req;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              rd_last;

  // store
  logic [BYTE_W-1:0] store_q [BUFFER_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_raddr;

  logic [BYTE_W:0]   tick_sum;
  logic [BYTE_W-1:0] tick_sat;

  // output register plus skid slot
  logic      push;
  uitf_res_t push_res;
  logic      out_valid_q, skid_valid_q;
  uitf_res_t out_res_q, skid_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TICK_PERIOD_RST;
      idle_limit_q  <= IDLE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (uitf_cfg_e'(cfg_idx_i))
        CFG_TICK_PERIOD: tick_period_q <= cfg_wdata_i;
        CFG_IDLE_LIMIT:  idle_limit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // n = min(read_length, count); count never exceeds the store depth
  assign rd_n_req = (read_length_i < BYTE_W'(count_q)) ? read_length_i[CNT_W-1:0] : count_q;
  assign rd_last  = (CNT_W'(idx_q) + CNT_W'(1)) == rd_n_q;
  assign tick_sum = {1'b0, timer_q} + {1'b0, tick_period_q};
  assign tick_sat = tick_sum[BYTE_W] ? '1 : tick_sum[BYTE_W-1:0];

  always_comb begin
    count_d = count_q;
    seen_d  = seen_q;
    timer_d = timer_q;
    flag_d  = flag_q;
    rd_n_d  = rd_n_q;
    idx_d   = idx_q;
    mem_we  = 1'b0;
    if (cmd_i.wr_byte && (count_q < CNT_W'(BUFFER_DEPTH))) begin
      mem_we  = 1'b1;
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.tick) begin
      if (count_q == '0) begin
        seen_d = '0;
      end else if (seen_q != count_q) begin
        seen_d  = count_q;
        timer_d = '0;
      end else if (timer_q < idle_limit_q) begin
        timer_d = tick_sat;
        if (tick_sat >= idle_limit_q) begin
          flag_d = 1'b1;
        end
      end
    end
    if (cmd_i.rd_clear) begin
      count_d = '0;
      seen_d  = '0;
      flag_d  = 1'b0;
      rd_n_d  = rd_n_req;
      idx_d   = '0;
    end
    if (cmd_i.push_data && !rd_last) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  // fetch byte 0 on read start, the next byte each time a non-final one is pushed
  assign mem_re    = cmd_i.rd_clear || (cmd_i.push_data && !rd_last);
  assign mem_raddr = cmd_i.rd_clear ? '0 : idx_q + IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      seen_q  <= '0;
      timer_q <= '0;
      flag_q  <= 1'b0;
      rd_n_q  <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      seen_q  <= seen_d;
      timer_q <= timer_d;
      flag_q  <= flag_d;
      rd_n_q  <= rd_n_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[count_q[IDX_W-1:0]] <= rx_byte_i;
    end
    if (mem_re) begin
      rdata_q <= store_q[mem_raddr];
    end
  end

  // result to emit this cycle
  always_comb begin
    push     = cmd_i.push_status || cmd_i.push_data;
    push_res = '0;
    if (cmd_i.push_data) begin
      push_res.data_byte       = rdata_q;
      push_res.data_valid      = 1'b1;
      push_res.last            = rd_last;
      push_res.frame_ready     = flag_q;
      push_res.returned_length = LEN_W'(rd_n_q);
    end else begin
      push_res.last            = 1'b1;
      push_res.frame_ready     = flag_d;
      push_res.returned_length = LEN_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_res_q <= skid_valid_q ? skid_res_q : push_res;
    end else if (push) begin
      skid_res_q <= push_res;
    end
  end

  assign sts_o.space   = !skid_valid_q;
  assign sts_o.rd_none = (rd_n_req == '0);
  assign sts_o.rd_last = rd_last;
  assign out_valid_o   = out_valid_q;
  assign out_res_o     = out_res_q;

endmodule

### hdl/uart_rx_idle_timeout_framer.sv
`timescale 1ns / 1ps
// Top level of the UART receive framer with idle-gap frame detection.
// Depends on uitf_pkg, uitf_if (uitf_in_if, uitf_out_if), uitf_ctrl and uitf_dp.
//
//  channel   dir  handshake          payload
//  in_if     in   valid / ready      opcode, rx_byte, read_length
//  out_if    out  valid / ready      data_byte, data_valid, last, frame_ready, returned_length
//  cfg       in   cfg_we_i           cfg_idx_i (0 tick_period, 1 idle_limit), cfg_wdata_i
//
// Byte, tick and unused-opcode transactions each give one result. A read first latches
// the length and fetches byte 0 from the store, then gives one byte per cycle while the
// output has space, a rate set by the single store read port.
// Results go through an output register with a one-entry skid slot, so one new
// transaction is taken while a result waits; input stalls when the slot is full or a read runs.
// Reset (rst_ni, async low) clears counts, timer, flag and config; the store needs no clearing.
module uart_rx_idle_timeout_framer #(
  parameter int unsigned BUFFER_DEPTH = uitf_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  uitf_in_if.sink                    in_if,
  uitf_out_if.source                 out_if,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [uitf_pkg::CFG_W-1:0] cfg_wdata_i
);
  import uitf_pkg::*;

  uitf_cmd_t cmd;
  uitf_sts_t sts;
  uitf_res_t out_res;
  logic      in_ready;
  logic      out_valid;

  // controller: owns the input handshake and the read sequence
  uitf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_opcode_i (in_if.opcode),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: store, frame state, idle timer and result buffering
  uitf_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rx_byte_i     (in_if.rx_byte),
    .read_length_i (in_if.read_length),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_if.ready),
    .out_res_o     (out_res)
  );

  assign in_if.ready            = in_ready;
  assign out_if.valid           = out_valid;
  assign out_if.data_byte       = out_res.data_byte;
  assign out_if.data_valid      = out_res.data_valid;
  assign out_if.last            = out_res.last;
  assign out_if.frame_ready     = out_res.frame_ready;
  assign out_if.returned_length = out_res.returned_length;

  // a read clears the flag before its bytes go out
  a_data_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data_valid |-> !out_if.frame_ready)
    else $error("data result carries frame_ready");

  // status results are single, zero-data and final
  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.data_valid |-> out_if.last && (out_if.data_byte == '0))
    else $error("malformed status result");

  // no new transaction while a read is being walked out
  a_no_accept_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_data |-> !in_if.ready)
    else $error("input accepted during read");

  // lengths stay within the store
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.returned_length <= LEN_W'(BUFFER_DEPTH)))
    else $error("returned_length beyond store depth");

endmodule
